>>> hdl/pqd_pkg.sv
package pqd_pkg;

  // Build-time defaults
  localparam int MAX_SIDE_DEF  = 64;
  localparam int GRID_SIDE_RST = 64;

  // Field widths
  localparam int SIDE_REG_W  = 7;
  localparam int PROB_W      = 17;
  localparam int CHANCE_W    = 16;
  localparam int COORD_IN_W  = 6;
  localparam int COUNT_OUT_W = 13;
  localparam int CMD_W       = 2;

  // Stream and register bus widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_GRID_SIDE = 2'd0,
    REG_BIRTH     = 2'd1,
    REG_FEEDBACK  = 2'd2,
    REG_DEATH     = 2'd3
  } reg_idx_t;

  // Input transaction payload, last field in the low bits
  typedef struct packed {
    logic [5:0]            pad;
    logic                  cell_value;
    logic [CHANCE_W-1:0]   chance_second;
    logic [CHANCE_W-1:0]   chance_first;
    logic [2:0]            pair_pick;
    logic [1:0]            neighbour_pick;
    logic [COORD_IN_W-1:0] site_col;
    logic [COORD_IN_W-1:0] site_row;
  } in_data_t;

  // Result transaction payload, last field in the low bits
  typedef struct packed {
    logic [6:0]             pad;
    logic                   death_done;
    logic                   feedback_done;
    logic                   birth_done;
    logic [COUNT_OUT_W-1:0] occupied_count;
    logic                   read_value;
  } out_data_t;

  typedef struct packed {
    logic [SIDE_REG_W-1:0] grid_side;
    logic [PROB_W-1:0]     birth_prob;
    logic [PROB_W-1:0]     feedback_prob;
    logic [PROB_W-1:0]     death_prob;
  } cfg_t;

  typedef enum logic [1:0] {
    ASEL_SITE  = 2'd0,
    ASEL_NEIGH = 2'd1,
    ASEL_PAIR  = 2'd2,
    ASEL_CLEAR = 2'd3
  } asel_t;

  typedef enum logic [1:0] {
    WBIT_ZERO = 2'd0,
    WBIT_ONE  = 2'd1,
    WBIT_ITEM = 2'd2
  } wbit_t;

  // Controller -> datapath
  typedef struct packed {
    logic  latch;
    logic  mem_rd;
    logic  mem_wr;
    asel_t asel;
    wbit_t wbit;
    logic  cnt_up;
    logic  cnt_dn;
    logic  rv_load;
    logic  rv_item;
    logic  set_born;
    logic  set_fed;
    logic  set_died;
    logic  clr_step;
    logic  load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic oob;
    logic q;
    logic wval;
    logic birth_hit;
    logic feed_hit;
    logic death_hit;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/pqd_lattice_update.sv
// Sequencing: each transaction is latched and checked against the grid; out-of-grid items
//   and command 3 go straight to the result, others make their dependent lattice accesses.
// Throughput: one transaction at a time; the single lattice port and the one-item-at-a-time
//   sequencer take a new one only after the last result is loaded into the result register.
// Reset: synchronous, active high; then a clearing pass over all MAX_SIDE*MAX_SIDE cells
//   (4096 at the default) with s_axis_tready low. Register writes are taken throughout.
module pqd_lattice_update #(
  parameter int MAX_SIDE = pqd_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // site_row[5:0], site_col[11:6], neighbour_pick[13:12], pair_pick[16:14],
  // chance_first[32:17], chance_second[48:33], cell_value[49], zero pad[55:50]
  input  logic [pqd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]: update, write cell, read cell, no-op
  input  logic [pqd_pkg::CMD_W-1:0]       s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_value[0], occupied_count[13:1], birth_done[14], feedback_done[15],
  // death_done[16], zero pad[23:17]
  output logic [pqd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status[0]: coordinate out of grid, transaction ignored
  output logic                            m_axis_tuser,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pqd_pkg::APB_AW-1:0]      paddr,
  input  logic [pqd_pkg::APB_DW-1:0]      pwdata,
  output logic [pqd_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import pqd_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Registers: grid_side @0x0, birth_prob @0x4, feedback_prob @0x8, death_prob @0xC.
  // The user must write them only while no transaction is in flight; the block does not enforce it.
  pqd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: clear pass, then per transaction a short chain of store accesses.
  // An update reads the focal site, then its neighbour, then the pair neighbour
  // if needed; birth/feedback and death writes each take their own store access.
  pqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Datapath: transaction registers, wrap arithmetic, lattice store, occupied
  // counter and the result register, which frees the sequencer while the
  // downstream side stalls.
  pqd_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

>>> hdl/pqd_regs.sv
module pqd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pqd_pkg::APB_AW-1:0] paddr,
  input  logic [pqd_pkg::APB_DW-1:0] pwdata,
  output logic [pqd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output pqd_pkg::cfg_t              cfg
);
  import pqd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_side     <= SIDE_REG_W'(GRID_SIDE_RST);
      cfg.birth_prob    <= '0;
      cfg.feedback_prob <= '0;
      cfg.death_prob    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_GRID_SIDE: cfg.grid_side     <= pwdata[SIDE_REG_W-1:0];
        REG_BIRTH:     cfg.birth_prob    <= pwdata[PROB_W-1:0];
        REG_FEEDBACK:  cfg.feedback_prob <= pwdata[PROB_W-1:0];
        REG_DEATH:     cfg.death_prob    <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_SIDE: prdata = APB_DW'(cfg.grid_side);
      REG_BIRTH:     prdata = APB_DW'(cfg.birth_prob);
      REG_FEEDBACK:  prdata = APB_DW'(cfg.feedback_prob);
      REG_DEATH:     prdata = APB_DW'(cfg.death_prob);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> hdl/pqd_ctrl.sv
module pqd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pqd_pkg::dp_stat_t  stat,
  output pqd_pkg::dp_cmd_t   cmd
);
  import pqd_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SITE,
    ST_FOCAL,
    ST_NEIGH,
    ST_PAIR,
    ST_DEATH,
    ST_RESULT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.mem_wr   = 1'b1;
        cmd.asel     = ASEL_CLEAR;
        cmd.wbit     = WBIT_ZERO;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_SITE;
        end
      end
      ST_SITE: begin
        if (stat.oob || stat.cmd == CMD_NOP) begin
          state_next = ST_RESULT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = ASEL_SITE;
          state_next = ST_FOCAL;
        end
      end
      ST_FOCAL: begin
        case (stat.cmd)
          CMD_WRITE: begin
            cmd.mem_wr  = 1'b1;
            cmd.asel    = ASEL_SITE;
            cmd.wbit    = WBIT_ITEM;
            cmd.cnt_up  = stat.wval & ~stat.q;
            cmd.cnt_dn  = ~stat.wval & stat.q;
            cmd.rv_load = 1'b1;
            cmd.rv_item = 1'b1;
            state_next  = ST_RESULT;
          end
          CMD_UPDATE: begin
            cmd.rv_load = 1'b1;
            if (stat.q) begin
              cmd.mem_rd = 1'b1;
              cmd.asel   = ASEL_NEIGH;
              state_next = ST_NEIGH;
            end else begin
              state_next = ST_RESULT;
            end
          end
          default: begin
            cmd.rv_load = 1'b1;
            state_next  = ST_RESULT;
          end
        endcase
      end
      ST_NEIGH: begin
        if (!stat.q) begin
          if (stat.birth_hit) begin
            cmd.mem_wr   = 1'b1;
            cmd.asel     = ASEL_NEIGH;
            cmd.wbit     = WBIT_ONE;
            cmd.cnt_up   = 1'b1;
            cmd.set_born = 1'b1;
          end
          state_next = stat.death_hit ? ST_DEATH : ST_RESULT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = ASEL_PAIR;
          state_next = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (stat.feed_hit) begin
          cmd.mem_wr  = 1'b1;
          cmd.asel    = ASEL_PAIR;
          cmd.wbit    = WBIT_ONE;
          cmd.cnt_up  = ~stat.q;
          cmd.set_fed = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          state_next = stat.death_hit ? ST_DEATH : ST_RESULT;
        end
      end
      ST_DEATH: begin
        cmd.mem_wr   = 1'b1;
        cmd.asel     = ASEL_SITE;
        cmd.wbit     = WBIT_ZERO;
        cmd.cnt_dn   = 1'b1;
        cmd.set_died = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

>>> hdl/pqd_dp.sv
module pqd_dp #(
  parameter int MAX_SIDE = pqd_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pqd_pkg::cfg_t                   cfg,
  input  logic [pqd_pkg::IN_TDATA_W-1:0]  in_data,
  input  logic [pqd_pkg::CMD_W-1:0]       in_user,
  input  pqd_pkg::dp_cmd_t                cmd,
  output pqd_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pqd_pkg::OUT_TDATA_W-1:0] out_data,
  output logic                            out_user
);
  import pqd_pkg::*;

  localparam int CELLS   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int CNT_W   = $clog2(CELLS + 1);

  in_data_t           item;
  cmd_t               item_cmd;
  logic [SIDE_W-1:0]  side;
  logic               oob;
  logic [COORD_W-1:0] row, col;
  logic [COORD_W-1:0] nr, nc, nr_next, nc_next;
  logic [COORD_W-1:0] pr, pc, pr_next, pc_next;
  logic [COORD_W-1:0] br, bc;
  logic [2:0]         pp;
  logic               vertical, up;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  clr_addr;
  logic               wbit;
  logic               mem [CELLS];
  logic               q;
  logic [CNT_W-1:0]   count;
  logic               rv, born, fed, died;
  out_data_t          res;

  function automatic logic [COORD_W-1:0] wrap_up(input logic [COORD_W-1:0] v,
                                                 input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] inc;
    inc = SIDE_W'(v) + SIDE_W'(1);
    return (inc >= s) ? '0 : COORD_W'(inc);
  endfunction

  function automatic logic [COORD_W-1:0] wrap_down(input logic [COORD_W-1:0] v,
                                                   input logic [SIDE_W-1:0] s);
    return (v == '0) ? COORD_W'(s - SIDE_W'(1)) : v - COORD_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
  endfunction

  // Side in use, clamped to [3, MAX_SIDE]
  always_comb begin
    if (cfg.grid_side < SIDE_REG_W'(3)) begin
      side = SIDE_W'(3);
    end else if (int'(cfg.grid_side) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(cfg.grid_side);
    end
  end

  assign oob = (item_cmd != CMD_NOP) &&
               ((int'(item.site_row) >= int'(side)) || (int'(item.site_col) >= int'(side)));

  // In-grid coordinates fit COORD_W; out-of-grid items never touch the store
  assign row = COORD_W'(item.site_row);
  assign col = COORD_W'(item.site_col);

  // Neighbour of the focal site
  always_comb begin
    nr_next = row;
    nc_next = col;
    case (item.neighbour_pick)
      2'd0:    nr_next = wrap_down(row, side);
      2'd1:    nr_next = wrap_up(row, side);
      2'd2:    nc_next = wrap_down(col, side);
      default: nc_next = wrap_up(col, side);
    endcase
  end

  // Neighbour of the site pair, built from the registered neighbour
  always_comb begin
    pp       = (item.pair_pick > 3'd5) ? 3'd5 : item.pair_pick;
    vertical = ~item.neighbour_pick[1];
    up       = ~pp[0];
    br       = (pp >= 3'd4) ? nr : row;
    bc       = (pp >= 3'd4) ? nc : col;
    pr_next  = row;
    pc_next  = col;
    if (pp == 3'd0) begin
      case (item.neighbour_pick)
        2'd0:    pr_next = wrap_up(row, side);
        2'd1:    pr_next = wrap_down(row, side);
        2'd2:    pc_next = wrap_up(col, side);
        default: pc_next = wrap_down(col, side);
      endcase
    end else if (pp == 3'd1) begin
      pr_next = nr;
      pc_next = nc;
      case (item.neighbour_pick)
        2'd0:    pr_next = wrap_down(nr, side);
        2'd1:    pr_next = wrap_up(nr, side);
        2'd2:    pc_next = wrap_down(nc, side);
        default: pc_next = wrap_up(nc, side);
      endcase
    end else begin
      pr_next = br;
      pc_next = bc;
      if (vertical) begin
        pc_next = up ? wrap_up(bc, side) : wrap_down(bc, side);
      end else begin
        pr_next = up ? wrap_up(br, side) : wrap_down(br, side);
      end
    end
  end

  // Neighbour is registered from the latched item, the pair from the registered neighbour
  always_ff @(posedge clk) begin
    nr <= nr_next;
    nc <= nc_next;
    pr <= pr_next;
    pc <= pc_next;
  end

  always_comb begin
    case (cmd.asel)
      ASEL_SITE:  addr = cell_addr(row, col);
      ASEL_NEIGH: addr = cell_addr(nr, nc);
      ASEL_PAIR:  addr = cell_addr(pr, pc);
      default:    addr = clr_addr;
    endcase
  end

  always_comb begin
    case (cmd.wbit)
      WBIT_ONE:  wbit = 1'b1;
      WBIT_ITEM: wbit = item.cell_value;
      default:   wbit = 1'b0;
    endcase
  end

  // Single-port lattice store
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= wbit;
    if (cmd.mem_rd) q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_up) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dn) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.clr_step) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item     <= in_data_t'(in_data);
      item_cmd <= cmd_t'(in_user);
      rv       <= 1'b0;
      born     <= 1'b0;
      fed      <= 1'b0;
      died     <= 1'b0;
    end else begin
      if (cmd.rv_load)  rv   <= cmd.rv_item ? item.cell_value : q;
      if (cmd.set_born) born <= 1'b1;
      if (cmd.set_fed)  fed  <= 1'b1;
      if (cmd.set_died) died <= 1'b1;
    end
    if (cmd.load_out) begin
      res.pad            <= '0;
      res.read_value     <= rv & ~died;
      res.occupied_count <= COUNT_OUT_W'(count);
      res.birth_done     <= born;
      res.feedback_done  <= fed;
      res.death_done     <= died;
      out_user           <= oob;
    end
  end

  assign out_data = res;

  assign stat.cmd       = item_cmd;
  assign stat.oob       = oob;
  assign stat.q         = q;
  assign stat.wval      = item.cell_value;
  assign stat.birth_hit = {1'b0, item.chance_first} < cfg.birth_prob;
  assign stat.feed_hit  = {1'b0, item.chance_first} < cfg.feedback_prob;
  assign stat.death_hit = {1'b0, item.chance_second} < cfg.death_prob;
  assign stat.clr_last  = (clr_addr == ADDR_W'(CELLS - 1));
  assign stat.out_free  = ~out_valid | out_ready;

endmodule

>>> hdl/pqd_checker.sv
module pqd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pqd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import pqd_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Reset starts the clear pass with both sides quiet
  a_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("not quiet after reset");

  // Ignored transaction reports nothing
  a_oob: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[0] == 1'b0 && m_axis_tdata[16:14] == 3'b000)
    else $error("out-of-grid result carries flags");

  // Birth and feedback lie on exclusive branches
  a_birth_fed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[14] && m_axis_tdata[15]))
    else $error("birth and feedback together");

  // Death only runs when feedback fails
  a_fed_died: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[15] && m_axis_tdata[16]))
    else $error("feedback and death together");

endmodule

bind pqd_lattice_update pqd_checker u_pqd_checker (.*);

>>> tb/testbench.sv
module testbench;
  import pqd_pkg::*;

  localparam int CELLS          = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int QUIET_PHASE    = 2;     // no random idling on either side
  localparam int HOLD_PHASE     = 4;     // receiver backs off for a long stretch
  localparam int HOLD_START     = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PCT       = 21;
  // covers the post-reset clear plus the long hold-off, with margin
  localparam int WATCHDOG_LIMIT = 12000;

  // neighbour pick codes
  localparam int unsigned NB_UP    = 0;
  localparam int unsigned NB_DOWN  = 1;
  localparam int unsigned NB_LEFT  = 2;
  localparam int unsigned NB_RIGHT = 3;
  // pair picks above this one fold onto it
  localparam int unsigned PAIR_LAST = 5;

  // Shadow lattice plus the queue of results it predicts.
  class lattice_tracker;
    typedef struct packed {
      out_data_t data;
      logic      status;
    } outcome_t;

    bit          cells [CELLS];
    int unsigned occupied;
    bit [6:0]    side_reg;
    bit [16:0]   birth_p, feed_p, death_p;
    outcome_t    pending_results [$];
    int          errors;

    function new();
      foreach (cells[i]) cells[i] = 1'b0;
      occupied = 0;
      side_reg = GRID_SIDE_RST;
      birth_p  = '0;
      feed_p   = '0;
      death_p  = '0;
      errors   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, int unsigned value);
      case (idx)
        REG_GRID_SIDE: side_reg = value[6:0];
        REG_BIRTH:     birth_p  = value[16:0];
        REG_FEEDBACK:  feed_p   = value[16:0];
        default:       death_p  = value[16:0];
      endcase
    endfunction

    function int unsigned reg_value(reg_idx_t idx);
      case (idx)
        REG_GRID_SIDE: return side_reg;
        REG_BIRTH:     return birth_p;
        REG_FEEDBACK:  return feed_p;
        default:       return death_p;
      endcase
    endfunction

    // side clamps to 3..MAX_SIDE
    function int unsigned active_side();
      if (side_reg < 3) return 3;
      if (side_reg > MAX_SIDE_DEF) return MAX_SIDE_DEF;
      return side_reg;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function int unsigned step_fwd(int unsigned v, int unsigned side);
      return (v + 1 >= side) ? 0 : v + 1;
    endfunction

    function int unsigned step_back(int unsigned v, int unsigned side);
      return (v == 0) ? side - 1 : v - 1;
    endfunction

    function int unsigned cell_index(int unsigned r, int unsigned c);
      return r * MAX_SIDE_DEF + c;
    endfunction

    function void store(int unsigned r, int unsigned c, bit v);
      int unsigned i;
      i = cell_index(r, c);
      if (cells[i] != v) begin
        if (v) occupied++;
        else occupied--;
        cells[i] = v;
      end
    endfunction

    // Work out the result of one accepted transaction and queue it.
    function void note_input(cmd_t op, in_data_t d);
      int unsigned side, r, c, nr, nc, pr, pc, br, bc, pp;
      bit          vert, up;
      outcome_t    want;
      side = active_side();
      r    = d.site_row;
      c    = d.site_col;
      want = '0;
      if (op != CMD_NOP && (r >= side || c >= side)) begin
        want.status = 1'b1;
      end else begin
        case (op)
          CMD_WRITE: begin
            store(r, c, d.cell_value);
            want.data.read_value = d.cell_value;
          end
          CMD_READ: want.data.read_value = cells[cell_index(r, c)];
          CMD_UPDATE: begin
            if (cells[cell_index(r, c)]) begin
              nr = r;
              nc = c;
              case (d.neighbour_pick)
                NB_UP:   nr = step_back(r, side);
                NB_DOWN: nr = step_fwd(r, side);
                NB_LEFT: nc = step_back(c, side);
                default: nc = step_fwd(c, side);
              endcase
              if (!cells[cell_index(nr, nc)]) begin
                // empty neighbour: birth and death tested independently
                if (d.chance_first < birth_p) begin
                  store(nr, nc, 1'b1);
                  want.data.birth_done = 1'b1;
                end
                if (d.chance_second < death_p) begin
                  store(r, c, 1'b0);
                  want.data.death_done = 1'b1;
                end
              end else begin
                // occupied neighbour: pick one of six cells around the pair
                pp   = (d.pair_pick > PAIR_LAST) ? PAIR_LAST : d.pair_pick;
                vert = (d.neighbour_pick < NB_LEFT);
                pr   = r;
                pc   = c;
                if (pp == 0) begin
                  case (d.neighbour_pick)
                    NB_UP:   pr = step_fwd(r, side);
                    NB_DOWN: pr = step_back(r, side);
                    NB_LEFT: pc = step_fwd(c, side);
                    default: pc = step_back(c, side);
                  endcase
                end else if (pp == 1) begin
                  pr = nr;
                  pc = nc;
                  case (d.neighbour_pick)
                    NB_UP:   pr = step_back(nr, side);
                    NB_DOWN: pr = step_fwd(nr, side);
                    NB_LEFT: pc = step_back(nc, side);
                    default: pc = step_fwd(nc, side);
                  endcase
                end else begin
                  br = (pp >= 4) ? nr : r;
                  bc = (pp >= 4) ? nc : c;
                  up = (pp % 2 == 0);
                  pr = br;
                  pc = bc;
                  if (vert) pc = up ? step_fwd(bc, side) : step_back(bc, side);
                  else pr = up ? step_fwd(br, side) : step_back(br, side);
                end
                // death only runs when feedback fails
                if (d.chance_first < feed_p) begin
                  store(pr, pc, 1'b1);
                  want.data.feedback_done = 1'b1;
                end else if (d.chance_second < death_p) begin
                  store(r, c, 1'b0);
                  want.data.death_done = 1'b1;
                end
              end
              want.data.read_value = cells[cell_index(r, c)];
            end
          end
          default: ;
        endcase
      end
      want.data.occupied_count = COUNT_OUT_W'(occupied);
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_data_t got, logic got_status);
      outcome_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %h status %b",
                 $time, got, got_status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_value", want.data.read_value, got.read_value);
      compare_field("occupied_count", want.data.occupied_count, got.occupied_count);
      compare_field("birth_done", want.data.birth_done, got.birth_done);
      compare_field("feedback_done", want.data.feedback_done, got.feedback_done);
      compare_field("death_done", want.data.death_done, got.death_done);
      compare_field("pad", want.data.pad, got.pad);
      compare_field("status", want.status, got_status);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   psel, penable, pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  lattice_tracker tracker = new();
  bit             idle_on;      // random idling on both stream sides
  bit             hold_req;     // sender asks the receiver for one long back-off
  int             idle_cycles = 0;

  // per-phase register settings; raw sides 2, 0 and 127 exercise the clamp
  int unsigned side_tab  [PHASES] = '{8, 64, 3, 2, 127, 5, 0, 11};
  int unsigned birth_tab [PHASES] = '{40000, 65536, 0, 32768, 50000, 131071, 20000, 17000};
  int unsigned feed_tab  [PHASES] = '{30000, 65536, 65536, 0, 20000, 65535, 60000, 45000};
  int unsigned death_tab [PHASES] = '{20000, 0, 65536, 10000, 65535, 1, 5000, 30000};

  pqd_lattice_update u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register write, then read back through the same port. One bus signal
  // gets one NBA per step, so the write's access phase runs straight into
  // the read's setup phase.
  task automatic program_reg(reg_idx_t idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(tracker.reg_value(idx))) begin
      $display("%0t: register %s readback mismatch, expected %0d, actual %0d",
               $time, idx.name(), tracker.reg_value(idx), prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned side, int unsigned birth, int unsigned feed,
                           int unsigned death);
    program_reg(REG_GRID_SIDE, side);
    program_reg(REG_BIRTH, birth);
    program_reg(REG_FEEDBACK, feed);
    program_reg(REG_DEATH, death);
  endtask

  // Offer one transaction; returns in the step right after it is accepted.
  task automatic send(cmd_t op, int unsigned row, int unsigned col, int unsigned nb,
                      int unsigned pp, int unsigned c1, int unsigned c2, bit val);
    in_data_t d;
    d                = '0;
    d.site_row       = COORD_IN_W'(row);
    d.site_col       = COORD_IN_W'(col);
    d.neighbour_pick = 2'(nb);
    d.pair_pick      = 3'(pp);
    d.chance_first   = CHANCE_W'(c1);
    d.chance_second  = CHANCE_W'(c2);
    d.cell_value     = val;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted result has come back.
  // It first waits for the clock so the monitor has logged the last accepted transaction.
  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly near the wrap corner so updates meet occupied cells; the rest
  // spans the whole field, out-of-grid values included.
  function automatic int unsigned pick_coord(int unsigned side);
    if ($urandom_range(0, 9) < 7) return (side - 3 + $urandom_range(0, 5)) % side;
    return $urandom_range(0, 63);
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Sample handshakes with pre-edge values; watchdog on stream progress.
  always @(posedge clk) begin : monitor
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_input(cmd_t'(s_axis_tuser), in_data_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(out_data_t'(m_axis_tdata), m_axis_tuser);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned side, roll;
    cmd_t        op;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_UPDATE;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Small grid, sure birth and death, no feedback.
    // Registers are taken during the clearing pass; the stream waits on tready.
    configure(4, 65536, 0, 65536);
    send(CMD_READ,   0,  0,  NB_UP,    0, 0,     0,     1'b0); // never-written cell
    send(CMD_WRITE,  0,  0,  NB_UP,    0, 0,     0,     1'b1);
    send(CMD_WRITE,  3,  3,  NB_DOWN,  0, 0,     0,     1'b1); // last row and column
    send(CMD_WRITE,  63, 63, NB_RIGHT, 7, 65535, 65535, 1'b1); // out of grid
    send(CMD_READ,   4,  0,  NB_LEFT,  0, 0,     0,     1'b0); // row just past side
    send(CMD_READ,   3,  3,  NB_UP,    0, 0,     0,     1'b0);
    send(CMD_UPDATE, 1,  1,  NB_DOWN,  0, 0,     0,     1'b0); // focal site empty
    // row wraps to the bottom; empty neighbour, both tests pass
    send(CMD_UPDATE, 0,  0,  NB_UP,    0, 0,     65535, 1'b0);
    send(CMD_NOP,    63, 63, NB_RIGHT, 7, 65535, 65535, 1'b1); // no-op command
    send(CMD_WRITE,  0,  1,  NB_UP,    0, 0,     0,     1'b1);
    send(CMD_WRITE,  0,  0,  NB_UP,    0, 0,     0,     1'b1);
    // occupied neighbour, pair pick folds, feedback fails, death runs
    send(CMD_UPDATE, 0,  0,  NB_RIGHT, 7, 65535, 0,     1'b0);
    send(CMD_WRITE,  0,  0,  NB_UP,    0, 0,     0,     1'b0);
    end_burst();

    // Minimum grid, sure feedback: every neighbour direction with an occupied pair.
    configure(3, 0, 65536, 0);
    send(CMD_WRITE,  1, 1, NB_UP, 0, 0, 0, 1'b1);
    send(CMD_WRITE,  0, 1, NB_UP, 0, 0, 0, 1'b1);
    send(CMD_WRITE,  2, 1, NB_UP, 0, 0, 0, 1'b1);
    send(CMD_WRITE,  1, 0, NB_UP, 0, 0, 0, 1'b1);
    send(CMD_WRITE,  1, 2, NB_UP, 0, 0, 0, 1'b1);
    send(CMD_UPDATE, 1, 1, NB_UP,    0, 65535, 65535, 1'b0);
    send(CMD_UPDATE, 1, 1, NB_DOWN,  1, 65535, 65535, 1'b0);
    send(CMD_UPDATE, 1, 1, NB_LEFT,  4, 65535, 65535, 1'b0);
    send(CMD_UPDATE, 1, 1, NB_RIGHT, 6, 65535, 65535, 1'b0);
    send(CMD_UPDATE, 2, 0, NB_LEFT,  3, 65535, 65535, 1'b0);
    end_burst();

    // Random phases. Cells written under one side stay (and count) when the
    // side shrinks; reads of them then come back flagged out of grid.
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(side_tab[ph], birth_tab[ph], feed_tab[ph], death_tab[ph]);
      idle_on = (ph != QUIET_PHASE);
      side    = tracker.active_side();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == HOLD_PHASE && n == HOLD_START) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        op   = (roll < 55) ? CMD_UPDATE : (roll < 80) ? CMD_WRITE :
               (roll < 95) ? CMD_READ : CMD_NOP;
        send(op, pick_coord(side), pick_coord(side), $urandom_range(0, 3),
             $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 65535),
             $urandom_range(0, 9) < 7);
      end
      end_burst();
    end

    // let any stray result show up before the verdict
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
